// ===== sv/pem_pkg.sv =====
// Shared types and constants of the Prewitt edge magnitude block.
`default_nettype none

package pem_pkg;

    // Configuration port
    localparam int CFG_W = 11;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd1000;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd1000;

    // Frame geometry
    localparam int DIM_MIN  = 3;
    localparam int ROWS_MAX = 1024;
    localparam int ROW_W    = 10;
    localparam int COORD_W  = 10;

    // Pixel and gradient widths
    localparam int PIXEL_IN_W = 8;
    localparam int GRAD_W     = 8;
    localparam logic [GRAD_W-1:0] GRAD_MAX = 8'd255;

    // Root unit: one result bit per step over a radicand of twice the result width
    localparam int ROOT_STEPS  = GRAD_W;
    localparam int RADICAND_W  = 2 * GRAD_W;
    localparam int STEP_CNT_W  = $clog2(ROOT_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_HOLD
    } state_t;

endpackage

`default_nettype wire

// ===== sv/pem_line_store.sv =====
// Synchronous line store memory with one write port and one registered read port.
`default_nettype none

module pem_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/pem_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
`default_nettype none

module pem_isqrt (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [pem_pkg::RADICAND_W-1:0] radicand,
    output logic                                done,
    output logic      [pem_pkg::GRAD_W-1:0]     root
);

    localparam int REM_W  = pem_pkg::GRAD_W + 1;
    localparam int WORK_W = REM_W + 2;

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [pem_pkg::STEP_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [pem_pkg::RADICAND_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]                rem_reg, rem_next;
    logic [pem_pkg::GRAD_W-1:0]      root_reg, root_next;

    logic [WORK_W-1:0] work;
    logic [WORK_W-1:0] trial;
    logic [WORK_W-1:0] diff;
    logic              fits;

    always_comb
    begin
        // bring down the next two radicand bits and try root*4+1
        work  = {rem_reg, rad_reg[pem_pkg::RADICAND_W-1 -: 2]};
        trial = {1'b0, root_reg, 2'b01};
        fits  = (work >= trial);
        diff  = work - trial;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = pem_pkg::STEP_CNT_W'(pem_pkg::ROOT_STEPS - 1);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = rad_reg << 2;
            rem_next  = fits ? diff[REM_W-1:0] : work[REM_W-1:0];
            root_next = {root_reg[pem_pkg::GRAD_W-2:0], fits};
            cnt_next  = cnt_reg - pem_pkg::STEP_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== sv/prewitt_edge_magnitude.sv =====
// Top level of the streaming 3x3 Prewitt edge magnitude block.
//
// Grey pixels enter in raster order, one request at a time. Each pixel reads its column
// of the line store (the two rows above, packed in one memory entry) by a registered read
// and writes the column back in the next cycle. A pixel that completes a 3x3 window (row
// 2 or later, column 2 or later) yields one result for the pixel one row up and one column
// left; border pixels yield none. A pixel with no result returns from the read state to
// idle; one with a result is squared and summed, then goes to the output hold state,
// directly if clamped to 255, else through the eight-step square root unit. A result
// waiting at the output stalls only if a second result is ready before the first is taken.
// The line store is not cleared after reset: the first two rows of a frame after reset
// give no result. A configuration write restarts the frame at row 0, column 0.
`default_nettype none

module prewitt_edge_magnitude #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [pem_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [pem_pkg::PIXEL_IN_W-1:0]    pixel,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [pem_pkg::GRAD_W-1:0]        gradient,
    output logic      [pem_pkg::COORD_W-1:0]       out_row,
    output logic      [pem_pkg::COORD_W-1:0]       out_col,
    output logic                                   last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int DIM_W = (COL_W + 1 > pem_pkg::CFG_W) ? COL_W + 1 : pem_pkg::CFG_W;
    localparam int IN_W  = (PIXEL_BITS < pem_pkg::PIXEL_IN_W) ? PIXEL_BITS
                                                               : pem_pkg::PIXEL_IN_W;
    localparam int SUM_W = PIXEL_BITS + 2;
    localparam int SQ_W  = 2 * SUM_W;
    localparam int SUM_X = (SQ_W + 1 > pem_pkg::RADICAND_W + 1) ? SQ_W + 1
                                                                 : pem_pkg::RADICAND_W + 1;

    // ---------------------------------------------------------------- configuration
    logic [pem_pkg::CFG_W-1:0] frame_width_reg;
    logic [pem_pkg::CFG_W-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= pem_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= pem_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pem_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                pem_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:                   frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    logic [DIM_W-1:0]          fw_ext;
    logic [DIM_W-1:0]          w_eff;
    logic [DIM_W-1:0]          w_last_full;
    logic [COL_W-1:0]          last_col;
    logic [pem_pkg::CFG_W-1:0] h_eff;
    logic [pem_pkg::CFG_W-1:0] h_last_full;
    logic [pem_pkg::ROW_W-1:0] last_row;

    always_comb
    begin
        // clamp the frame size to what the counters and line store can cover
        fw_ext = DIM_W'(frame_width_reg);
        if (fw_ext < DIM_W'(pem_pkg::DIM_MIN))
            w_eff = DIM_W'(pem_pkg::DIM_MIN);
        else if (fw_ext > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = fw_ext;
        w_last_full = w_eff - DIM_W'(1);
        last_col    = w_last_full[COL_W-1:0];

        if (frame_height_reg < pem_pkg::CFG_W'(pem_pkg::DIM_MIN))
            h_eff = pem_pkg::CFG_W'(pem_pkg::DIM_MIN);
        else if (frame_height_reg > pem_pkg::CFG_W'(pem_pkg::ROWS_MAX))
            h_eff = pem_pkg::CFG_W'(pem_pkg::ROWS_MAX);
        else
            h_eff = frame_height_reg;
        h_last_full = h_eff - pem_pkg::CFG_W'(1);
        last_row    = h_last_full[pem_pkg::ROW_W-1:0];
    end

    // ---------------------------------------------------------------- control
    pem_pkg::state_t state_reg, state_next;

    logic in_accept;
    logic out_free;
    logic mem_wr;
    logic root_start;
    logic out_load;
    logic emit_reg;
    logic over;
    logic root_done;
    logic out_valid_reg;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pem_pkg::ST_IDLE:   if (in_accept) state_next = pem_pkg::ST_READ;
            pem_pkg::ST_READ:   state_next = emit_reg ? pem_pkg::ST_SQUARE : pem_pkg::ST_IDLE;
            pem_pkg::ST_SQUARE: state_next = pem_pkg::ST_SUM;
            pem_pkg::ST_SUM:    state_next = over ? pem_pkg::ST_HOLD : pem_pkg::ST_ROOT;
            pem_pkg::ST_ROOT:   if (root_done) state_next = pem_pkg::ST_HOLD;
            pem_pkg::ST_HOLD:   if (out_free) state_next = pem_pkg::ST_IDLE;
            default:            state_next = pem_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        mem_wr     = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            pem_pkg::ST_IDLE:   in_stall   = 1'b0;
            pem_pkg::ST_READ:   mem_wr     = 1'b1;
            pem_pkg::ST_SQUARE: in_stall   = 1'b1;
            pem_pkg::ST_SUM:    root_start = !over;
            pem_pkg::ST_ROOT:   in_stall   = 1'b1;
            pem_pkg::ST_HOLD:   out_load   = out_free;
            default:            in_stall   = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pem_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------------------------------------------------------- position counters
    logic [COL_W-1:0]          col_reg, col_next;
    logic [pem_pkg::ROW_W-1:0] row_reg, row_next;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_accept)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + pem_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------- accepted pixel
    logic [PIXEL_BITS-1:0]     px_in;
    logic [PIXEL_BITS-1:0]     px_reg;
    logic [COL_W-1:0]          c_reg;
    logic [pem_pkg::ROW_W-1:0] r_reg;
    logic                      frame_end_reg;

    assign px_in = PIXEL_BITS'(pixel[IN_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            emit_reg <= 1'b0;
        else if (in_accept)
            emit_reg <= (row_reg >= pem_pkg::ROW_W'(2)) && (col_reg >= COL_W'(2));
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            px_reg        <= px_in;
            c_reg         <= col_reg;
            r_reg         <= row_reg;
            frame_end_reg <= (row_reg == last_row) && (col_reg == last_col);
        end
    end

    // ---------------------------------------------------------------- line store
    logic [2*PIXEL_BITS-1:0] rd_data;
    logic [PIXEL_BITS-1:0]   top;
    logic [PIXEL_BITS-1:0]   mid;

    pem_line_store #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (2 * PIXEL_BITS)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (mem_wr),
        .wr_addr (c_reg),
        .wr_data ({mid, px_reg})
    );

    assign top = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign mid = rd_data[PIXEL_BITS-1:0];

    // ---------------------------------------------------------------- window and sums
    logic [PIXEL_BITS-1:0] win_reg [6];
    logic [SUM_W-1:0]      left_sum, right_sum, up_sum, down_sum;
    logic [SUM_W-1:0]      ax_reg, ay_reg;

    always_comb
    begin
        left_sum  = SUM_W'(win_reg[0]) + SUM_W'(win_reg[1]) + SUM_W'(win_reg[2]);
        right_sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(px_reg);
        up_sum    = SUM_W'(win_reg[0]) + SUM_W'(win_reg[3]) + SUM_W'(top);
        down_sum  = SUM_W'(win_reg[2]) + SUM_W'(win_reg[5]) + SUM_W'(px_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (mem_wr)
        begin
            // advance the window by one column
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= px_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            ax_reg <= (left_sum >= right_sum) ? left_sum - right_sum : right_sum - left_sum;
            ay_reg <= (up_sum >= down_sum) ? up_sum - down_sum : down_sum - up_sum;
        end
    end

    // ---------------------------------------------------------------- magnitude
    logic [SQ_W-1:0]                 sq_x_reg, sq_y_reg;
    logic [SUM_X-1:0]                sum_sq;
    logic [pem_pkg::GRAD_W-1:0]      root;
    logic [pem_pkg::GRAD_W-1:0]      grad_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == pem_pkg::ST_SQUARE)
        begin
            sq_x_reg <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
            sq_y_reg <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
        end
    end

    assign sum_sq = SUM_X'(sq_x_reg) + SUM_X'(sq_y_reg);
    // a root above 255 means the sum spills past the radicand width
    assign over   = |sum_sq[SUM_X-1:pem_pkg::RADICAND_W];

    pem_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sum_sq[pem_pkg::RADICAND_W-1:0]),
        .done     (root_done),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == pem_pkg::ST_SUM && over)
            grad_reg <= pem_pkg::GRAD_MAX;
        else if (state_reg == pem_pkg::ST_ROOT && root_done)
            grad_reg <= root;
    end

    // ---------------------------------------------------------------- output register
    logic [pem_pkg::GRAD_W-1:0]  gradient_reg;
    logic [pem_pkg::COORD_W-1:0] out_row_reg;
    logic [pem_pkg::COORD_W-1:0] out_col_reg;
    logic                        last_reg;
    logic [pem_pkg::ROW_W-1:0]   r_prev;
    logic [COL_W-1:0]            c_prev;

    assign r_prev = r_reg - pem_pkg::ROW_W'(1);
    assign c_prev = c_reg - COL_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            gradient_reg <= grad_reg;
            out_row_reg  <= pem_pkg::COORD_W'(r_prev);
            out_col_reg  <= pem_pkg::COORD_W'(c_prev);
            last_reg     <= frame_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign gradient  = gradient_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== sv/pem_checker.sv =====
// Port-level checker for the Prewitt edge magnitude block, bound to the top level.
`default_nettype none

module pem_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [pem_pkg::GRAD_W-1:0]    gradient,
    input wire logic [pem_pkg::COORD_W-1:0]   out_row,
    input wire logic [pem_pkg::COORD_W-1:0]   out_col,
    input wire logic                          last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable(gradient) && $stable(out_row) && $stable(out_col) && $stable(last))
        else $error("stalled result changed or dropped");

    // one request in flight: stall straight after each accepted pixel
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second pixel accepted before the first was processed");

    // a new result is only loaded while the input side is stalled
    a_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a pixel in flight");

    // results are never on the top border row
    a_interior_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_row != '0)
        else $error("result on border row");

endmodule

bind prewitt_edge_magnitude pem_checker u_pem_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the streaming Prewitt edge magnitude block.
module tb_top;

    localparam int LINE_DEPTH    = 1024;
    localparam int LINE_AW       = $clog2(LINE_DEPTH);
    localparam int SETTLE_CYCLES = 24;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_PIXELS = 1650;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT       = 100;
    localparam int PAUSE_AT      = 400;

    typedef enum int { TONE_NOISE, TONE_SMOOTH, TONE_BINARY } tone_t;

    typedef struct packed {
        logic [pem_pkg::GRAD_W-1:0]  grad;
        logic [pem_pkg::COORD_W-1:0] row;
        logic [pem_pkg::COORD_W-1:0] col;
        logic                        last;
    } edge_result_t;

    typedef struct {
        logic [pem_pkg::PIXEL_IN_W-1:0] px;
        bit                             typed;
        logic [pem_pkg::GRAD_W-1:0]     grad;
    } pixel_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic                           cfg_index;
    logic [pem_pkg::CFG_W-1:0]      cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic [pem_pkg::PIXEL_IN_W-1:0] pixel;
    logic                           out_valid;
    logic                           out_stall;
    logic [pem_pkg::GRAD_W-1:0]     gradient;
    logic [pem_pkg::COORD_W-1:0]    out_row;
    logic [pem_pkg::COORD_W-1:0]    out_col;
    logic                           last;

    // Predictor state
    logic [pem_pkg::PIXEL_IN_W-1:0] line_prev  [LINE_DEPTH];
    logic [pem_pkg::PIXEL_IN_W-1:0] line_prev2 [LINE_DEPTH];
    logic [pem_pkg::PIXEL_IN_W-1:0] win [6];
    int unsigned                    pix_col;
    int unsigned                    pix_row;
    logic [pem_pkg::CFG_W-1:0]      width_reg;
    logic [pem_pkg::CFG_W-1:0]      height_reg;

    edge_result_t gradient_q [$];
    int           errors;
    int           quiet_cycles;
    int           rand_count;
    bit           calm;
    bit           sink_hold_req;
    int           hold_left;
    int           stall_run;

    // Three 3x3 frames: flat, left edge (clamped), lone corner pixel (sqrt of 32)
    pixel_row_t directed_rows [0:26] = '{
        '{8'd255, 1'b0, 8'd0}, '{8'd255, 1'b0, 8'd0}, '{8'd255, 1'b0, 8'd0},
        '{8'd255, 1'b0, 8'd0}, '{8'd255, 1'b0, 8'd0}, '{8'd255, 1'b0, 8'd0},
        '{8'd255, 1'b0, 8'd0}, '{8'd255, 1'b0, 8'd0}, '{8'd255, 1'b1, 8'd0},
        '{8'd255, 1'b0, 8'd0}, '{8'd0,   1'b0, 8'd0}, '{8'd0,   1'b0, 8'd0},
        '{8'd255, 1'b0, 8'd0}, '{8'd0,   1'b0, 8'd0}, '{8'd0,   1'b0, 8'd0},
        '{8'd255, 1'b0, 8'd0}, '{8'd0,   1'b0, 8'd0}, '{8'd0,   1'b1, 8'd255},
        '{8'd4,   1'b0, 8'd0}, '{8'd0,   1'b0, 8'd0}, '{8'd0,   1'b0, 8'd0},
        '{8'd0,   1'b0, 8'd0}, '{8'd0,   1'b0, 8'd0}, '{8'd0,   1'b0, 8'd0},
        '{8'd0,   1'b0, 8'd0}, '{8'd0,   1'b0, 8'd0}, '{8'd0,   1'b1, 8'd5}
    };

    prewitt_edge_magnitude #(
        .MAX_WIDTH  (LINE_DEPTH),
        .PIXEL_BITS (pem_pkg::PIXEL_IN_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .gradient  (gradient),
        .out_row   (out_row),
        .out_col   (out_col),
        .last      (last)
    );

    always #6 clk = ~clk;

    function automatic int unsigned dim_in_use(logic [pem_pkg::CFG_W-1:0] code);
        if (code < pem_pkg::CFG_W'(pem_pkg::DIM_MIN))
            return pem_pkg::DIM_MIN;
        if (code > pem_pkg::CFG_W'(pem_pkg::ROWS_MAX))
            return pem_pkg::ROWS_MAX;
        return 32'(code);
    endfunction

    function automatic logic [pem_pkg::GRAD_W-1:0] clamped_root(int unsigned sum);
        int unsigned m;
        m = 0;
        while (m < 32'(pem_pkg::GRAD_MAX) && (m + 1) * (m + 1) <= sum)
            m++;
        return m[pem_pkg::GRAD_W-1:0];
    endfunction

    // Advance the window and line stores by one pixel; return 1 when a result is due
    function automatic bit prewitt_step(input logic [pem_pkg::PIXEL_IN_W-1:0] px,
                                        output edge_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          gx;
        int          gy;
        logic [LINE_AW-1:0]             ci;
        logic [pem_pkg::PIXEL_IN_W-1:0] top;
        logic [pem_pkg::PIXEL_IN_W-1:0] mid;
        bit          hit;
        w = dim_in_use(width_reg);
        h = dim_in_use(height_reg);
        c = pix_col;
        r = pix_row;
        ci = c[LINE_AW-1:0];
        hit = 1'b0;
        res = '0;
        top = line_prev2[ci];
        mid = line_prev[ci];
        line_prev2[ci] = mid;
        line_prev[ci] = px;
        if (r >= 2 && c >= 2)
        begin
            gx = (int'(win[0]) + int'(win[1]) + int'(win[2]))
               - (int'(top) + int'(mid) + int'(px));
            gy = (int'(win[0]) + int'(win[3]) + int'(top))
               - (int'(win[2]) + int'(win[5]) + int'(px));
            res.grad = clamped_root(gx * gx + gy * gy);
            res.row  = pem_pkg::COORD_W'(r - 1);
            res.col  = pem_pkg::COORD_W'(c - 1);
            res.last = (r == h - 1 && c == w - 1);
            hit = 1'b1;
        end
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = px;
        if (c == w - 1)
        begin
            pix_col = 0;
            pix_row = (r == h - 1) ? 0 : r + 1;
        end
        else
            pix_col = c + 1;
        return hit;
    endfunction

    function automatic int source_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [pem_pkg::PIXEL_IN_W-1:0] next_pixel(
        tone_t tone, logic [pem_pkg::PIXEL_IN_W-1:0] prev);
        int v;
        case (tone)
            TONE_SMOOTH:
            begin
                v = int'(prev) + int'($urandom_range(0, 16)) - 8;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                return v[pem_pkg::PIXEL_IN_W-1:0];
            end
            TONE_BINARY:
                return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default:
                return pem_pkg::PIXEL_IN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Hold until every expected result has been taken
    task automatic drain();
        do
            @(posedge clk);
        while (gradient_q.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [pem_pkg::CFG_W-1:0] value);
        in_valid <= 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == pem_pkg::REG_FRAME_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        pix_col = 0;
        pix_row = 0;
    endtask

    task automatic push_pixel(input logic [pem_pkg::PIXEL_IN_W-1:0] px, input bit typed,
                              input logic [pem_pkg::GRAD_W-1:0] grad);
        int           gap;
        bit           hit;
        edge_result_t res;
        gap = source_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= px;
        do
            @(posedge clk);
        while (in_stall);
        hit = prewitt_step(px, res);
        if (hit)
        begin
            if (typed)
                res = '{grad: grad, row: pem_pkg::COORD_W'(1), col: pem_pkg::COORD_W'(1),
                        last: 1'b1};
            gradient_q.push_back(res);
        end
    endtask

    function automatic logic [pem_pkg::CFG_W-1:0] dim_code(int d);
        if (d == pem_pkg::DIM_MIN && $urandom_range(0, 1) == 1)
            return pem_pkg::CFG_W'($urandom_range(0, pem_pkg::DIM_MIN));
        return pem_pkg::CFG_W'(d);
    endfunction

    task automatic run_random_phase();
        int unsigned                    w;
        int unsigned                    h;
        int unsigned                    n;
        tone_t                          tone;
        logic [pem_pkg::PIXEL_IN_W-1:0] px;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70) : $urandom_range(3, 24);
        h = $urandom_range(3, 10);
        case ($urandom_range(0, 4))
            0: write_reg(pem_pkg::REG_FRAME_WIDTH, dim_code(w));
            1: write_reg(pem_pkg::REG_FRAME_HEIGHT, dim_code(h));
            2:
            begin
                write_reg(pem_pkg::REG_FRAME_HEIGHT, dim_code(h));
                write_reg(pem_pkg::REG_FRAME_WIDTH, dim_code(w));
            end
            default:
            begin
                write_reg(pem_pkg::REG_FRAME_WIDTH, dim_code(w));
                write_reg(pem_pkg::REG_FRAME_HEIGHT, dim_code(h));
            end
        endcase
        w = dim_in_use(width_reg);
        h = dim_in_use(height_reg);
        calm = ($urandom_range(0, 3) == 0);
        tone = tone_t'($urandom_range(0, 2));
        n = $urandom_range(1, 3) * w * h;
        // End some phases mid-frame so the next write cuts a frame short
        if ($urandom_range(0, 3) == 0)
            n += $urandom_range(1, w * h - 1);
        px = pem_pkg::PIXEL_IN_W'($urandom_range(0, 255));
        for (int unsigned k = 0; k < n && rand_count < RANDOM_PIXELS; k++)
        begin
            px = next_pixel(tone, px);
            push_pixel(px, 1'b0, '0);
            rand_count++;
            if (rand_count == HOLD_AT)
                sink_hold_req = 1'b1;
            if (rand_count == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                drain();
            end
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        hold_left = 0;
        stall_run = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (gradient_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: gradient %0d row %0d col %0d",
                             $time, gradient, out_row, out_col);
                    errors++;
                end
                else
                begin
                    edge_result_t exp_r;
                    exp_r = gradient_q.pop_front();
                    check_field("gradient", int'(exp_r.grad), int'(gradient));
                    check_field("out_row", int'(exp_r.row), int'(out_row));
                    check_field("out_col", int'(exp_r.col), int'(out_col));
                    check_field("last", int'(exp_r.last), int'(last));
                end
            end
            if (sink_hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_run > 0)
            begin
                stall_run--;
                out_stall <= 1'b1;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
            begin
                int roll;
                roll = $urandom_range(0, 999);
                if (roll < 10)
                    stall_run = $urandom_range(20, 60);
                out_stall <= (roll < 300);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= pem_pkg::REG_FRAME_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        pixel     <= '0;
        quiet_cycles = 0;
        errors = 0;
        rand_count = 0;
        calm = 1'b0;
        sink_hold_req = 1'b0;
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            line_prev[i]  = '0;
            line_prev2[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win[i] = '0;
        pix_col = 0;
        pix_row = 0;
        width_reg  = pem_pkg::FRAME_WIDTH_RESET;
        height_reg = pem_pkg::FRAME_HEIGHT_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(pem_pkg::REG_FRAME_WIDTH, 11'd3);
        write_reg(pem_pkg::REG_FRAME_HEIGHT, 11'd3);
        foreach (directed_rows[i])
            push_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].grad);

        while (rand_count < RANDOM_PIXELS)
            run_random_phase();

        in_valid <= 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && gradient_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== prewitt_edge_magnitude.f =====
sv/pem_pkg.sv
sv/pem_line_store.sv
sv/pem_isqrt.sv
sv/prewitt_edge_magnitude.sv
sv/pem_checker.sv
tb/tb_top.sv
